[hdl/tlbda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbda_pkg - shared definitions for the bitmap descriptor allocator
// Field widths, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package tlbda_pkg;

  // Default table geometry
  localparam int DEF_TABLE_SLOTS = 256;
  localparam int DEF_WORD_BITS   = 64;

  // Field widths fixed by the request/result formats
  localparam int SLOT_W     = 13;   // min_slot, slot_limit, candidate slot
  localparam int GRANT_W    = 8;    // granted_slot
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;   // 13 + 1 bits, padded to bytes
  localparam int OUT_DATA_W = 16;   // 8 + 2 bits, padded to bytes

  localparam logic [SLOT_W-1:0] LIMIT_RESET = SLOT_W'(256);

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEEK,
    S_LOOK,
    S_FINISH
  } state_t;

endpackage

[hdl/tlbda_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbda_ram - generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tlbda_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Hold read data between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/tlbda_ffz.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbda_ffz - lowest free bit in one bitmap word
// Ignores bits below the start offset and, in the last word, bits past the
// end of the table.
// ----------------------------------------------------------------------------
module tlbda_ffz #(
  parameter int WORD_BITS = 64,
  parameter int LAST_BITS = 64,
  parameter int BIT_W     = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [BIT_W-1:0]     off,
  input  logic                 last,
  output logic                 found,
  output logic [BIT_W-1:0]     idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    // Walk down so the lowest qualifying bit wins
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i] && (BIT_W'(i) >= off) && (!last || (i < LAST_BITS))) begin
        found = 1'b1;
        idx   = BIT_W'(i);
      end
    end
  end

endmodule

[hdl/two_level_bitmap_descriptor_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_bitmap_descriptor_allocator - lowest-free slot allocator
// Open and close-on-exec bitmaps in RAM, one summary bit per whole word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                    payload (low bit first)
//  -------  ---  ---------------------------  ------------------------------
//  s_axis   in   s_axis_tvalid/s_axis_tready  min_slot[12:0], exec_close_flag
//  m_axis   out  m_axis_tvalid/m_axis_tready  granted_slot[7:0], status[1:0]
//  cfg      in   cfg_we                       slot_limit[12:0]
//
//  Steps: a request whose first candidate word holds a free slot passes
//  accept, word read, find-first-zero and write back. A word marked full is
//  skipped without a read; after a word read without a hit the search goes
//  on with the next word. A start at or past the table end goes from accept
//  straight to write back. One request is in work at a time.
//  Reset: after rst falls, a clearing pass writes zeros to every RAM word, one
//  word a cycle; no request is taken meanwhile.
//  Stalls: the result waits in an output register; a new request is taken
//  while it waits, and the write back holds until the register is free.
// ----------------------------------------------------------------------------
module two_level_bitmap_descriptor_allocator
  import tlbda_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int WORD_BITS   = DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: slot_limit
  input  logic                  cfg_we,
  input  logic [SLOT_W-1:0]     cfg_wdata,    // slot_limit[12:0]
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata, // min_slot[12:0], exec_close_flag[13]
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata  // granted_slot[7:0], status[9:8]
);

  // --------------------------------------------------------------------------
  // Geometry
  // --------------------------------------------------------------------------
  localparam int NUM_WORDS   = (TABLE_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WHOLE_WORDS = TABLE_SLOTS / WORD_BITS;
  localparam int LAST_BITS   = TABLE_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
  localparam int WADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WIDX_W      = $clog2(NUM_WORDS + 1);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int HINT_W      = $clog2(TABLE_SLOTS + 1);
  // Word index of the start slot by reciprocal multiply (exact for 13-bit slots)
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;

  localparam logic [SLOT_W-1:0] TABLE_END = SLOT_W'(TABLE_SLOTS);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state, state_next;
  logic [WADDR_W-1:0]  clr_idx, clr_idx_next;
  logic [HINT_W-1:0]   hint, hint_next;
  logic [NUM_WORDS-1:0] full_words, full_words_next;
  logic [SLOT_W-1:0]   slot_limit, slot_limit_next;
  logic                out_valid, out_valid_next;

  // Request payload, no reset
  logic [WIDX_W-1:0]   w, w_next;
  logic [WIDX_W-1:0]   first_w, first_w_next;
  logic [SLOT_W-1:0]   start, start_next;
  logic [SLOT_W-1:0]   cand, cand_next;
  logic [SLOT_W-1:0]   base, base_next;
  logic [BIT_W-1:0]    off, off_next;
  logic                is_last, is_last_next;
  logic [BIT_W-1:0]    fidx, fidx_next;
  logic                flag, flag_next;
  logic                min_le_hint, min_le_hint_next;
  logic [GRANT_W-1:0]  out_slot, out_slot_next;
  status_t             out_status, out_status_next;

  // --------------------------------------------------------------------------
  // Bitmap RAMs and word search
  // --------------------------------------------------------------------------
  logic                 ram_we, ram_re;
  logic [WADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] open_wdata, exec_wdata, open_rdata, exec_rdata;
  logic                 ffz_found;
  logic [BIT_W-1:0]     ffz_idx;

  tlbda_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS), .ADDR_W(WADDR_W)) u_open_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (open_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (open_rdata)
  );

  tlbda_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS), .ADDR_W(WADDR_W)) u_exec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (exec_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (exec_rdata)
  );

  tlbda_ffz #(.WORD_BITS(WORD_BITS), .LAST_BITS(LAST_BITS), .BIT_W(BIT_W)) u_ffz (
    .word  (open_rdata),
    .off   (off),
    .last  (is_last),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  // --------------------------------------------------------------------------
  // Next state and outputs
  // --------------------------------------------------------------------------
  logic [SLOT_W-1:0]    in_min;
  logic [SLOT_W-1:0]    hint_ext;
  logic [SLOT_W-1:0]    in_start;
  logic [31:0]          quot_prod;
  logic [SLOT_W-1:0]    seek_base;
  logic [SLOT_W-1:0]    off_full;
  logic [WORD_BITS-1:0] slot_bit;
  logic [WORD_BITS-1:0] open_new;

  assign in_min    = s_axis_tdata[SLOT_W-1:0];
  assign hint_ext  = SLOT_W'(hint);
  assign in_start  = (in_min < hint_ext) ? hint_ext : in_min;
  assign quot_prod = 32'(in_start) * 32'(RECIP_MULT);
  assign seek_base = SLOT_W'(32'(w) * 32'(WORD_BITS));
  assign off_full  = start - seek_base;
  assign slot_bit  = WORD_BITS'(1) << fidx;
  assign open_new  = open_rdata | slot_bit;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - GRANT_W - STATUS_W)'(0), out_status, out_slot};

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    hint_next        = hint;
    full_words_next  = full_words;
    slot_limit_next  = cfg_we ? cfg_wdata : slot_limit;
    out_valid_next   = out_valid && !m_axis_tready;
    w_next           = w;
    first_w_next     = first_w;
    start_next       = start;
    cand_next        = cand;
    base_next        = base;
    off_next         = off;
    is_last_next     = is_last;
    fidx_next        = fidx;
    flag_next        = flag;
    min_le_hint_next = min_le_hint;
    out_slot_next    = out_slot;
    out_status_next  = out_status;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = w[WADDR_W-1:0];
    ram_raddr        = w[WADDR_W-1:0];
    open_wdata       = open_new;
    exec_wdata       = flag ? (exec_rdata | slot_bit) : (exec_rdata & ~slot_bit);

    unique case (state)
      S_CLEAR: begin
        // Zero one word of each bitmap per cycle
        ram_we     = 1'b1;
        ram_waddr  = clr_idx;
        open_wdata = '0;
        exec_wdata = '0;
        clr_idx_next = clr_idx + WADDR_W'(1);
        if (clr_idx == WADDR_W'(NUM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          start_next       = in_start;
          flag_next        = s_axis_tdata[SLOT_W];
          min_le_hint_next = (in_min <= hint_ext);
          w_next           = quot_prod[RECIP_SHIFT +: WIDX_W];
          first_w_next     = quot_prod[RECIP_SHIFT +: WIDX_W];
          if (in_start >= TABLE_END) begin
            // No search: the start itself is the candidate
            cand_next  = in_start;
            state_next = S_FINISH;
          end else begin
            state_next = S_SEEK;
          end
        end
      end

      S_SEEK: begin
        if (w == WIDX_W'(NUM_WORDS)) begin
          cand_next  = TABLE_END;
          state_next = S_FINISH;
        end else if (full_words[w[WADDR_W-1:0]]) begin
          // Skip a word marked full
          w_next = w + WIDX_W'(1);
        end else begin
          ram_re       = 1'b1;
          base_next    = seek_base;
          off_next     = (w == first_w) ? off_full[BIT_W-1:0] : '0;
          is_last_next = (w == WIDX_W'(NUM_WORDS - 1));
          state_next   = S_LOOK;
        end
      end

      S_LOOK: begin
        if (ffz_found) begin
          fidx_next  = ffz_idx;
          cand_next  = base + SLOT_W'(ffz_idx);
          state_next = S_FINISH;
        end else begin
          w_next     = w + WIDX_W'(1);
          state_next = S_SEEK;
        end
      end

      S_FINISH: begin
        // Hold until the result register is free
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_slot_next  = '0;
          state_next     = S_IDLE;
          priority if (cand >= slot_limit) begin
            out_status_next = ST_LIMIT;
          end else if (cand >= TABLE_END) begin
            out_status_next = ST_FULL;
          end else begin
            out_status_next = ST_GRANTED;
            out_slot_next   = cand[GRANT_W-1:0];
            ram_we          = 1'b1;
            if ((open_new == '1) && (w < WIDX_W'(WHOLE_WORDS))) begin
              full_words_next[w[WADDR_W-1:0]] = 1'b1;
            end
            if (min_le_hint) begin
              hint_next = HINT_W'(cand + SLOT_W'(1));
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      hint       <= '0;
      full_words <= '0;
      slot_limit <= LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      hint       <= hint_next;
      full_words <= full_words_next;
      slot_limit <= slot_limit_next;
      out_valid  <= out_valid_next;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    w           <= w_next;
    first_w     <= first_w_next;
    start       <= start_next;
    cand        <= cand_next;
    base        <= base_next;
    off         <= off_next;
    is_last     <= is_last_next;
    fidx        <= fidx_next;
    flag        <= flag_next;
    min_le_hint <= min_le_hint_next;
    out_slot    <= out_slot_next;
    out_status  <= out_status_next;
  end

endmodule
